FILE: rtl/first_fit_extent_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the extent allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define FFA_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define FFA_ASSERT_IMPL(label, clk, rst_n, a, c)
`define FFA_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the extent allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;
	localparam int MaxExtents  = 16;
	localparam int MaxRecords  = 16;
	localparam int HeaderBytes = 8;
	localparam int AddrBits    = 20;
	localparam int LenBits     = AddrBits + 1;
	localparam int ExtIdxBits  = $clog2(MaxExtents);
	localparam int RecIdxBits  = $clog2(MaxRecords);
	localparam int ExtCntBits  = $clog2(MaxExtents + 1);
	localparam int RecCntBits  = $clog2(MaxRecords + 1);
	localparam int PadBits     = 8;

	localparam logic [1:0] StOk      = 2'd0;
	localparam logic [1:0] StNoFit   = 2'd1;
	localparam logic [1:0] StFull    = 2'd2;
	localparam logic [1:0] StUnknown = 2'd3;

	// shift command for the extent chain
	localparam logic [1:0] ShNone  = 2'd0;
	localparam logic [1:0] ShLeft  = 2'd1;
	localparam logic [1:0] ShRight = 2'd2;

	typedef struct packed {
		logic [AddrBits-1:0] start;
		logic [LenBits-1:0]  len;
	} extent_t;

	typedef struct packed {
		logic                  wr;
		logic [ExtIdxBits-1:0] idx;
		extent_t               data;
		logic [1:0]            shift;
		logic [ExtIdxBits-1:0] pos;
		logic                  init;
		extent_t               init_data;
	} ext_ctl_t;
endpackage

FILE: rtl/first_fit_extent_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_unit
// First-fit extent allocator with a record table and neighbor coalescing.
// ----------------------------------------------------------------------------
// channel  | handshake       | payload
// in       | in_valid/stall  | kind, req_size, align_log2, release_address
// out      | out_valid/stall | granted_address, status, bytes_in_use, live_count
// cfg      | cfg_we          | cfg_wdata (arena_size)
// One transaction at a time. Allocate: the walk visits the extents in order
// until one fits, else it ends with an end check; the output state then raises
// out_valid. Free: record lookup, position search, merge, then the output state.
// Early rejects go straight to the output state. The extent walk through the
// cell row decides how long a transaction takes.
// Reset clears extent count, records and totals; no clearing pass.
// A result waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
`include "first_fit_extent_allocator_unit_defines.svh"
module first_fit_extent_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [20:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [20:0] req_size,
	input  logic [2:0]  align_log2,
	input  logic [19:0] release_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [19:0] granted_address,
	output logic [1:0]  status,
	output logic [20:0] bytes_in_use,
	output logic [4:0]  live_count
);
	localparam int AB = ffa_pkg::AddrBits;
	localparam int LB = ffa_pkg::LenBits;
	localparam int EI = ffa_pkg::ExtIdxBits;
	localparam int EC = ffa_pkg::ExtCntBits;
	localparam int RI = ffa_pkg::RecIdxBits;
	localparam int RC = ffa_pkg::RecCntBits;
	localparam int PB = ffa_pkg::PadBits;
	localparam logic [LB-1:0] Cap = LB'(1) << AB;

	localparam logic [2:0] SIdle = 3'd0;
	localparam logic [2:0] SWalk = 3'd1;
	localparam logic [2:0] SFree = 3'd2;
	localparam logic [2:0] SPos  = 3'd3;
	localparam logic [2:0] SMrg  = 3'd4;
	localparam logic [2:0] SOut  = 3'd5;

	logic [2:0]    state_q;
	logic [EC-1:0] ecount_q;
	logic [EC-1:0] walk_q;
	logic [LB-1:0] size_q;
	logic [2:0]    alog_q;
	logic [AB-1:0] raddr_q;
	logic [RI-1:0] rec_q;
	logic [AB-1:0] bstart_q;
	logic [LB-1:0] bsize_q;
	logic [LB-1:0] used_q;
	logic [RC-1:0] live_q;
	logic [AB-1:0] res_addr_q;
	logic [1:0]    res_st_q;
	logic          out_valid_q;

	logic [AB-1:0] rec_addr_q [ffa_pkg::MaxRecords];
	logic [PB-1:0] rec_pad_q  [ffa_pkg::MaxRecords];
	logic [LB-1:0] rec_len_q  [ffa_pkg::MaxRecords];
	logic [ffa_pkg::MaxRecords-1:0] rec_valid_q;

	ffa_pkg::ext_ctl_t ctl;
	ffa_pkg::extent_t  rd_ent, rd_prev;
	logic [EI-1:0]     rd_idx;

	ffa_chain u_chain (.clk(clk), .ctl(ctl), .rd_idx(rd_idx),
		.rd_ent(rd_ent), .rd_prev(rd_prev));

	assign rd_idx = walk_q[EI-1:0];
	assign in_stall = (state_q != SIdle) || out_valid_q;
	wire accept = in_valid && !in_stall;

	// record searches
	logic          free_found, hit_found;
	logic [RI-1:0] free_idx, hit_idx;
	always_comb begin
		free_found = 1'b0; free_idx = '0; hit_found = 1'b0; hit_idx = '0;
		for (int r = ffa_pkg::MaxRecords - 1; r >= 0; r--) begin
			if (!rec_valid_q[r]) begin
				free_found = 1'b1; free_idx = RI'(r);
			end
			if (rec_valid_q[r] && rec_addr_q[r] == raddr_q) begin
				hit_found = 1'b1; hit_idx = RI'(r);
			end
		end
	end

	// fit test on the current extent
	logic [LB:0]   amask, s_hdr, pad_w, total;
	logic [LB-1:0] rest;
	logic          fits, whole;
	always_comb begin
		amask = (LB+1)'((1 << alog_q) - 1);
		s_hdr = ((LB+1)'(rd_ent.start) + (LB+1)'(ffa_pkg::HeaderBytes) + amask) & ~amask;
		pad_w = s_hdr - (LB+1)'(rd_ent.start);
		total = (LB+1)'(size_q) + pad_w;
		fits  = (LB+1)'(rd_ent.len) >= total;
		rest  = LB'((LB+1)'(rd_ent.len) - total);
		whole = rest <= LB'(ffa_pkg::HeaderBytes);
	end

	wire [LB-1:0] bend = LB'(bsize_q) + LB'(bstart_q);
	wire mprev = (walk_q != '0) &&
		(LB'(rd_prev.start) + rd_prev.len == LB'(bstart_q));
	wire mnext = (walk_q < ecount_q) && (LB'(rd_ent.start) == bend);

	logic [LB-1:0] cfg_sz;
	assign cfg_sz = (cfg_wdata > Cap) ? Cap : cfg_wdata;

	always_comb begin
		ctl = '0;
		ctl.init = cfg_we;
		ctl.init_data.start = '0;
		ctl.init_data.len = cfg_sz;
		ctl.idx = rd_idx;
		ctl.pos = rd_idx;
		if (state_q == SWalk && walk_q < ecount_q && fits) begin
			if (whole) begin
				ctl.shift = ffa_pkg::ShLeft;
			end else begin
				ctl.wr = 1'b1;
				ctl.data.start = AB'(LB'(rd_ent.start) + LB'(total));
				ctl.data.len = rest;
			end
		end
		if (state_q == SMrg) begin
			if (mprev && mnext) begin
				ctl.wr = 1'b1;
				ctl.idx = rd_idx - 1'b1;
				ctl.data.start = rd_prev.start;
				ctl.data.len = rd_prev.len + bsize_q + rd_ent.len;
				ctl.shift = ffa_pkg::ShLeft;
			end else if (mprev) begin
				ctl.wr = 1'b1;
				ctl.idx = rd_idx - 1'b1;
				ctl.data.start = rd_prev.start;
				ctl.data.len = rd_prev.len + bsize_q;
			end else if (mnext) begin
				ctl.wr = 1'b1;
				ctl.data.start = bstart_q;
				ctl.data.len = rd_ent.len + bsize_q;
			end else if (ecount_q < EC'(ffa_pkg::MaxExtents)) begin
				ctl.wr = 1'b1;
				ctl.data.start = bstart_q;
				ctl.data.len = bsize_q;
				ctl.shift = ffa_pkg::ShRight;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SWalk && walk_q < ecount_q && fits) begin
			rec_addr_q[free_idx] <= AB'(s_hdr);
			rec_pad_q[free_idx]  <= PB'(pad_w);
			rec_len_q[free_idx]  <= whole ? rd_ent.len : LB'(total);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SIdle; ecount_q <= '0; walk_q <= '0; rec_valid_q <= '0;
			used_q <= '0; live_q <= '0; out_valid_q <= 1'b0;
			size_q <= '0; alog_q <= '0; raddr_q <= '0; rec_q <= '0;
			bstart_q <= '0; bsize_q <= '0; res_addr_q <= '0; res_st_q <= '0;
		end else if (cfg_we) begin
			ecount_q <= (cfg_sz != '0) ? EC'(1) : '0;
			rec_valid_q <= '0; used_q <= '0; live_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				SIdle: begin
					if (accept) begin
						size_q <= req_size; alog_q <= align_log2;
						raddr_q <= release_address; walk_q <= '0;
						res_addr_q <= '0;
						if (!kind && req_size == '0) begin
							res_st_q <= ffa_pkg::StNoFit;
							state_q <= SOut;
						end else if (!kind && rec_valid_q == '1) begin
							res_st_q <= ffa_pkg::StFull;
							state_q <= SOut;
						end else begin
							state_q <= kind ? SFree : SWalk;
						end
					end
				end
				SWalk: begin
					if (walk_q >= ecount_q) begin
						res_st_q <= ffa_pkg::StNoFit; state_q <= SOut;
					end else if (fits) begin
						rec_valid_q[free_idx] <= 1'b1;
						used_q <= used_q + (whole ? rd_ent.len : LB'(total));
						live_q <= live_q + 1'b1;
						if (whole) ecount_q <= ecount_q - 1'b1;
						res_addr_q <= AB'(s_hdr); res_st_q <= ffa_pkg::StOk;
						state_q <= SOut;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				SFree: begin
					if (!hit_found) begin
						res_st_q <= ffa_pkg::StUnknown; state_q <= SOut;
					end else begin
						rec_q <= hit_idx;
						bstart_q <= rec_addr_q[hit_idx] - AB'(rec_pad_q[hit_idx]);
						bsize_q <= rec_len_q[hit_idx];
						state_q <= SPos;
					end
				end
				SPos: begin
					if (walk_q >= ecount_q || LB'(rd_ent.start) >= bend) state_q <= SMrg;
					else walk_q <= walk_q + 1'b1;
				end
				SMrg: begin
					state_q <= SOut;
					if (!mprev && !mnext && ecount_q >= EC'(ffa_pkg::MaxExtents)) begin
						res_st_q <= ffa_pkg::StFull;
					end else begin
						res_st_q <= ffa_pkg::StOk;
						rec_valid_q[rec_q] <= 1'b0;
						used_q <= used_q - bsize_q;
						live_q <= live_q - 1'b1;
						if (mprev && mnext) ecount_q <= ecount_q - 1'b1;
						else if (!mprev && !mnext) ecount_q <= ecount_q + 1'b1;
					end
				end
				SOut: begin
					out_valid_q <= 1'b1; state_q <= SIdle;
				end
				default: state_q <= SIdle;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign granted_address = res_addr_q;
	assign status = res_st_q;
	assign bytes_in_use = used_q;
	assign live_count = live_q;

	`FFA_ASSERT_IMPL(a_busy_stall, clk, arst_n, state_q != SIdle, in_stall)
	`FFA_ASSERT_IMPL(a_ecount_max, clk, arst_n, 1'b1, ecount_q <= EC'(ffa_pkg::MaxExtents))
	`FFA_ASSERT_IMPL(a_live_cnt, clk, arst_n, 1'b1, live_q == RC'($countones(rec_valid_q)))
	`FFA_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall && !cfg_we, out_valid && $stable(status))
endmodule

FILE: rtl/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// One extent slot of the chain; loads, holds, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module ffa_cell (
	input  logic                          clk,
	input  logic [ffa_pkg::ExtIdxBits-1:0] my_idx,
	input  ffa_pkg::ext_ctl_t              ctl,
	input  ffa_pkg::extent_t               left_in,
	input  ffa_pkg::extent_t               right_in,
	output ffa_pkg::extent_t               ent
);
	ffa_pkg::extent_t ent_q;
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			ent_q <= ctl.init_data;
		end else if (ctl.wr && ctl.idx == my_idx) begin
			ent_q <= ctl.data;
		end else if (ctl.shift == ffa_pkg::ShLeft && my_idx >= ctl.pos) begin
			ent_q <= right_in;
		end else if (ctl.shift == ffa_pkg::ShRight && my_idx > ctl.pos) begin
			ent_q <= left_in;
		end
	end
endmodule

FILE: rtl/ffa_chain.sv
// ----------------------------------------------------------------------------
// ffa_chain
// Row of extent cells; each hands its entry to its neighbors on a shift.
// ----------------------------------------------------------------------------
module ffa_chain (
	input  logic                                   clk,
	input  ffa_pkg::ext_ctl_t                      ctl,
	input  logic [ffa_pkg::ExtIdxBits-1:0]         rd_idx,
	output ffa_pkg::extent_t                       rd_ent,
	output ffa_pkg::extent_t                       rd_prev
);
	ffa_pkg::extent_t ents [ffa_pkg::MaxExtents];

	for (genvar g = 0; g < ffa_pkg::MaxExtents; g++) begin : g_cell
		ffa_pkg::extent_t l_in, r_in;
		if (g == 0) begin : g_l
			assign l_in = ents[g];
		end else begin : g_lo
			assign l_in = ents[g-1];
		end
		if (g == ffa_pkg::MaxExtents - 1) begin : g_r
			assign r_in = ents[g];
		end else begin : g_ro
			assign r_in = ents[g+1];
		end
		ffa_cell u_cell (
			.clk(clk), .my_idx(ffa_pkg::ExtIdxBits'(g)), .ctl(ctl),
			.left_in(l_in), .right_in(r_in), .ent(ents[g])
		);
	end

	assign rd_ent  = ents[rd_idx];
	assign rd_prev = ents[rd_idx - 1'b1];
endmodule
